// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("port check failed");

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("port check failed");

`endif

// ===== sv/arcs_pkg.sv =====
// types, constants and sequencer tables of the axial rope cos/sin generator
`default_nettype none

package arcs_pkg;

    localparam int ROPE_DIM   = 64;
    localparam int NFREQ      = ROPE_DIM / 4;
    localparam int FIDX_W     = (NFREQ > 1) ? $clog2(NFREQ) : 1;
    localparam int FREQ_IDX_W = 5;
    localparam int IDX_W      = 16;
    localparam int DIVCNT_W   = $clog2(IDX_W);
    localparam int N_STEPS    = 33;
    localparam int STEP_W     = $clog2(N_STEPS);
    localparam int CFG_IDX_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_RATIO     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_SCALE = 8'd3;

    localparam logic [8:0]  RST_GRID_WIDTH     = 9'd72;
    localparam logic [8:0]  RST_GRID_HEIGHT    = 9'd72;
    localparam logic [31:0] RST_FREQ_RATIO     = 32'd2415237493;
    localparam logic [23:0] RST_POSITION_SCALE = 24'd65536;

    // floor(2^64 / 2pi) split into low and high words
    localparam logic [31:0] K_LO     = 32'h9391054A;
    localparam logic [29:0] K_HI     = 30'h28BE60DB;
    localparam logic [32:0] HALF_PI  = 33'h1921FB544;
    localparam logic [32:0] F_ONE    = 33'h1_0000_0000;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_DIV,
        S_AXIS,
        S_CALC,
        S_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_RANGE,
        OP_DIV_STEP,
        OP_LOAD_X,
        OP_LOAD_Y,
        OP_FK_LO,
        OP_FK_HI,
        OP_F_RATIO,
        OP_TG_LO,
        OP_TG_HI,
        OP_PHASE,
        OP_ANGLE,
        OP_SQUARE,
        OP_SIN_FIRST,
        OP_CORRECT,
        OP_MUL_XT,
        OP_RECIP,
        OP_SIN_END,
        OP_COS_FIRST,
        OP_COS_END,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        D72,
        D42,
        D20,
        D6,
        D90,
        D56,
        D30,
        D12
    } t_div;

    typedef struct packed {
        t_op               op;
        t_div              div;
        logic [FIDX_W-1:0] freq;
        logic              axis;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic out_free;
    } t_status;

    // micro program of one cos/sin pair
    function automatic t_op prog_op(input logic [STEP_W-1:0] step);
        t_op op;
        unique case (step)
            6'd0:  op = OP_FK_LO;
            6'd1:  op = OP_FK_HI;
            6'd2:  op = OP_F_RATIO;
            6'd3:  op = OP_TG_LO;
            6'd4:  op = OP_TG_HI;
            6'd5:  op = OP_PHASE;
            6'd6:  op = OP_ANGLE;
            6'd7:  op = OP_SQUARE;
            6'd8:  op = OP_SIN_FIRST;
            6'd9, 6'd12, 6'd15, 6'd18, 6'd21, 6'd24, 6'd27, 6'd30: op = OP_CORRECT;
            6'd10, 6'd13, 6'd16, 6'd22, 6'd25, 6'd28, 6'd31:       op = OP_MUL_XT;
            6'd11, 6'd14, 6'd17, 6'd23, 6'd26, 6'd29:              op = OP_RECIP;
            6'd19: op = OP_SIN_END;
            6'd20: op = OP_COS_FIRST;
            6'd32: op = OP_COS_END;
            default: op = OP_NOP;
        endcase
        return op;
    endfunction

    function automatic t_div prog_div(input logic [STEP_W-1:0] step);
        t_div d;
        unique case (step)
            6'd11, 6'd12: d = D42;
            6'd14, 6'd15: d = D20;
            6'd17, 6'd18: d = D6;
            6'd20, 6'd21: d = D90;
            6'd23, 6'd24: d = D56;
            6'd26, 6'd27: d = D30;
            6'd29, 6'd30: d = D12;
            default:      d = D72;
        endcase
        return d;
    endfunction

    // floor(2^36 / d)
    function automatic logic [35:0] recip(input t_div d);
        logic [35:0] r;
        unique case (d)
            D72: r = 36'd954437176;
            D42: r = 36'd1636178017;
            D20: r = 36'd3435973836;
            D6:  r = 36'd11453246122;
            D90: r = 36'd763549741;
            D56: r = 36'd1227133513;
            D30: r = 36'd2290649224;
            D12: r = 36'd5726623061;
            default: r = 36'd954437176;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] divisor(input t_div d);
        logic [6:0] v;
        unique case (d)
            D72: v = 7'd72;
            D42: v = 7'd42;
            D20: v = 7'd20;
            D6:  v = 7'd6;
            D90: v = 7'd90;
            D56: v = 7'd56;
            D30: v = 7'd30;
            D12: v = 7'd12;
            default: v = 7'd72;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/arcs_ctrl.sv =====
// sequencer of the axial rope cos/sin generator
`default_nettype none

module arcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  arcs_pkg::t_status i_status,
    output arcs_pkg::t_cmd   o_cmd
);
    import arcs_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [STEP_W-1:0]   r_step;
    logic [FIDX_W-1:0]   r_freq;
    logic                r_axis;
    logic [DIVCNT_W-1:0] r_divcnt;

    logic freq_end;
    logic step_end;
    logic div_end;
    logic last_pair;

    assign freq_end  = (r_freq == FIDX_W'(NFREQ - 1));
    assign step_end  = (r_step == STEP_W'(N_STEPS - 1));
    assign div_end   = (r_divcnt == DIVCNT_W'(IDX_W - 1));
    assign last_pair = r_axis && freq_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_freq   <= '0;
            r_axis   <= 1'b0;
            r_divcnt <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_freq   <= '0;
                        r_axis   <= 1'b0;
                        r_divcnt <= '0;
                    end
                end
                S_DIV:  r_divcnt <= r_divcnt + 1'b1;
                S_AXIS: r_step   <= '0;
                S_CALC: r_step   <= r_step + 1'b1;
                S_EMIT: begin
                    if (i_status.out_free && !last_pair) begin
                        r_step <= '0;
                        if (freq_end) begin
                            r_freq <= '0;
                            r_axis <= 1'b1;
                        end else begin
                            r_freq <= r_freq + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) n_state = S_RANGE;
            S_RANGE: n_state = S_DIV;
            S_DIV: begin
                if (i_status.oor) n_state = S_EMIT;
                else if (div_end) n_state = S_AXIS;
            end
            S_AXIS:  n_state = S_CALC;
            S_CALC:  if (step_end) n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    if (last_pair)         n_state = S_IDLE;
                    else if (i_status.oor) n_state = S_EMIT;
                    else if (freq_end)     n_state = S_AXIS;
                    else                   n_state = S_CALC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = OP_NOP;
        o_cmd.div  = prog_div(r_step);
        o_cmd.freq = r_freq;
        o_cmd.axis = r_axis;
        o_cmd.last = last_pair;
        o_s_axis_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE:  if (i_s_axis_tvalid) o_cmd.op = OP_LOAD;
            S_RANGE: o_cmd.op = OP_RANGE;
            S_DIV:   if (!i_status.oor) o_cmd.op = OP_DIV_STEP;
            S_AXIS:  o_cmd.op = r_axis ? OP_LOAD_Y : OP_LOAD_X;
            S_CALC:  o_cmd.op = prog_op(r_step);
            S_EMIT:  if (i_status.out_free) o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/arcs_datapath.sv =====
// registers, shared multiplier and output stage of the generator
`default_nettype none

module arcs_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  arcs_pkg::t_cmd                     i_cmd,
    output arcs_pkg::t_status                  o_status,
    input  logic [arcs_pkg::IDX_W-1:0]         i_index,
    input  logic                               i_cfg_valid,
    input  logic [arcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  logic                               i_m_axis_tready,
    output logic                               o_m_axis_tvalid,
    output logic [arcs_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast,
    output logic [arcs_pkg::OUT_USER_W-1:0]    o_m_axis_tuser
);
    import arcs_pkg::*;

    // configuration
    logic [8:0]  r_grid_w;
    logic [8:0]  r_grid_h;
    logic [31:0] r_ratio;
    logic [23:0] r_scale;

    // working registers
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_quo;
    logic [8:0]       r_rem;
    logic             r_oor;
    logic [32:0]      r_t;
    logic [32:0]      r_f;
    logic [32:0]      r_acc;
    logic [62:0]      r_g;
    logic [68:0]      r_prod;
    logic [1:0]       r_quad;
    logic             r_fold;
    logic [21:0]      r_rp;
    logic [30:0]      r_x;
    logic [31:0]      r_x2;
    logic [31:0]      r_v;
    logic [30:0]      r_tt;
    logic [30:0]      r_s;
    logic [30:0]      r_c;

    // output stage
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;
    logic [OUT_USER_W-1:0] r_out_user;

    logic [32:0] mul_a;
    logic [35:0] mul_b;
    logic [68:0] mul_p;
    logic [30:0] prod_x;
    logic [31:0] prod_v;

    assign prod_x = r_prod[54:24];
    assign prod_v = r_prod[61:30];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_FK_LO:     begin mul_a = r_f; mul_b = {4'b0, K_LO}; end
            OP_FK_HI:     begin mul_a = r_f; mul_b = {6'b0, K_HI}; end
            OP_F_RATIO:   begin mul_a = r_f; mul_b = {4'b0, r_ratio}; end
            OP_TG_LO:     begin mul_a = r_t; mul_b = {4'b0, r_g[31:0]}; end
            OP_TG_HI:     begin mul_a = r_t; mul_b = {5'b0, r_g[62:32]}; end
            OP_ANGLE:     begin mul_a = {11'b0, r_rp}; mul_b = {3'b0, HALF_PI}; end
            OP_SQUARE:    begin mul_a = {2'b0, prod_x}; mul_b = {5'b0, prod_x}; end
            OP_SIN_FIRST: begin mul_a = {1'b0, prod_v}; mul_b = recip(i_cmd.div); end
            OP_COS_FIRST: begin mul_a = {1'b0, r_x2}; mul_b = recip(i_cmd.div); end
            OP_MUL_XT:    begin mul_a = {1'b0, r_x2}; mul_b = {5'b0, r_tt}; end
            OP_RECIP:     begin mul_a = {1'b0, prod_v}; mul_b = recip(i_cmd.div); end
            OP_SIN_END:   begin mul_a = {2'b0, r_x}; mul_b = {5'b0, r_tt}; end
            default:      begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = {36'b0, mul_a} * {33'b0, mul_b};

    // grid split and range check
    logic [17:0] grid_size;
    logic [9:0]  rem_sh;
    logic        rem_ge;

    assign grid_size = {9'b0, r_grid_w} * {9'b0, r_grid_h};
    assign rem_sh    = {r_rem, r_quo[IDX_W-1]};
    assign rem_ge    = (rem_sh >= {1'b0, r_grid_w});

    // phase and fold
    logic [47:0] phase_sum;
    logic [23:0] phase;
    logic [21:0] phase_r;
    logic        fold;

    assign phase_sum = r_prod[47:0] + {15'b0, r_acc};
    assign phase     = phase_sum[47:24];
    assign phase_r   = phase[21:0];
    assign fold      = (phase_r > 22'h20_0000);

    // quotient correction after reciprocal multiply
    logic [31:0] q0;
    logic [6:0]  dval;
    logic [38:0] qd;
    logic [38:0] rmd;
    logic [31:0] q;

    assign q0   = r_prod[67:36];
    assign dval = divisor(i_cmd.div);
    assign qd   = {7'b0, q0} * {32'b0, dval};
    assign rmd  = {7'b0, r_v} - qd;
    assign q    = q0 + {31'b0, (rmd >= {32'b0, dval})};

    // sign and rounding of the result pair
    logic [30:0] cm_raw;
    logic [30:0] sm_raw;
    logic [31:0] cm_rnd;
    logic [31:0] sm_rnd;
    logic [15:0] cm;
    logic [15:0] sm;
    logic [15:0] cos_val;
    logic [15:0] sin_val;

    assign cm_raw = r_fold ? r_s : r_c;
    assign sm_raw = r_fold ? r_c : r_s;
    assign cm_rnd = {1'b0, cm_raw} + 32'h4000;
    assign sm_rnd = {1'b0, sm_raw} + 32'h4000;
    assign cm     = cm_rnd[30:15];
    assign sm     = sm_rnd[30:15];

    function automatic logic [15:0] pos_out(input logic [15:0] mag);
        return mag[15] ? 16'h7FFF : mag;
    endfunction

    always_comb begin
        unique case (r_quad)
            2'd0:    begin cos_val = pos_out(cm); sin_val = pos_out(sm); end
            2'd1:    begin cos_val = -sm;         sin_val = pos_out(cm); end
            2'd2:    begin cos_val = -cm;         sin_val = -sm;         end
            default: begin cos_val = pos_out(sm); sin_val = -cm;         end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= RST_GRID_WIDTH;
            r_grid_h <= RST_GRID_HEIGHT;
            r_ratio  <= RST_FREQ_RATIO;
            r_scale  <= RST_POSITION_SCALE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:     r_grid_w <= i_cfg_data[8:0];
                CFG_GRID_HEIGHT:    r_grid_h <= i_cfg_data[8:0];
                CFG_FREQ_RATIO:     r_ratio  <= i_cfg_data;
                CFG_POSITION_SCALE: r_scale  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (i_cmd.op)
            OP_LOAD: r_idx <= i_index;
            OP_RANGE: begin
                r_oor <= ({2'b0, r_idx} >= grid_size);
                r_quo <= r_idx;
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_ge ? 9'(rem_sh - {1'b0, r_grid_w}) : rem_sh[8:0];
                r_quo <= {r_quo[IDX_W-2:0], rem_ge};
            end
            OP_LOAD_X: begin
                r_t <= {24'b0, r_rem} * {9'b0, r_scale};
                r_f <= F_ONE;
            end
            OP_LOAD_Y: begin
                r_t <= {24'b0, r_quo[8:0]} * {9'b0, r_scale};
                r_f <= F_ONE;
            end
            OP_FK_HI:   r_acc <= r_prod[64:32];
            OP_F_RATIO: r_g   <= r_prod[62:0] + {30'b0, r_acc};
            OP_TG_LO: begin
                r_f <= 33'((r_prod[64:0] + 65'h8000_0000) >> 32);
            end
            OP_TG_HI: r_acc <= r_prod[64:32];
            OP_PHASE: begin
                r_quad <= phase[23:22];
                r_fold <= fold;
                r_rp   <= fold ? 22'(23'h40_0000 - {1'b0, phase_r}) : phase_r;
            end
            OP_SQUARE: r_x <= prod_x;
            OP_SIN_FIRST: begin
                r_x2 <= prod_v;
                r_v  <= prod_v;
            end
            OP_CORRECT:   r_tt <= ONE_Q30 - q[30:0];
            OP_RECIP:     r_v  <= prod_v;
            // the cosine series divides the square again
            OP_COS_FIRST: begin
                r_s <= r_prod[60:30];
                r_v <= r_x2;
            end
            OP_COS_END:   r_c  <= ONE_Q30 - {1'b0, prod_v[30:1]} - {prod_v[31], 30'b0};
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_out_data <= {3'b0,
                           r_oor ? 16'h0 : sin_val,
                           r_oor ? 16'h0 : cos_val,
                           FREQ_IDX_W'(i_cmd.freq)};
            r_out_last <= i_cmd.last;
            r_out_user <= {r_oor, i_cmd.axis};
        end
    end

    assign o_status.oor      = r_oor;
    assign o_status.out_free = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== sv/axial_rope_cos_sin_generator.sv =====
// top level of the axial rope cos/sin generator
`default_nettype none

// Takes one flat grid position per input word and returns ROPE_DIM/2 output
// words: cosine and sine (Q1.15) of the scaled column times each of the
// ROPE_DIM/4 frequencies, then the same for the row, the final word marked by
// tlast. Frequencies start at 1.0 and step by freq_ratio (Q0.32), coordinates
// are scaled by position_scale (Q8.16). An index at or beyond width*height
// still yields all words, with zero cosine and sine and the out_of_range flag.
// One shared 33x36 multiplier runs a 33-step micro program per pair
// (frequency update, turn rate, phase, then the sine and cosine series),
// then the pair is handed to the output register once that is free. Before
// the first pair the index is split bit-serially by the grid width; an out
// of range item skips the split and the series and only emits its words.
// The next item is taken once the last word sits in the output register.
// Registers must be written only while idle; the block does not enforce it.
module axial_rope_cos_sin_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input word: [15:0] position_index
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,
    // output word: [4:0] frequency_index, [20:5] cosine, [36:21] sine,
    // [39:37] zero
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [arcs_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    output logic                              o_m_axis_tlast,
    // tuser: [0] axis, [1] out_of_range
    output logic [arcs_pkg::OUT_USER_W-1:0]   o_m_axis_tuser,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [arcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import arcs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // writes are always taken; they must come while the block is idle, which it does not enforce
    assign o_cfg_ready = 1'b1;

    arcs_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    arcs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_index         (i_s_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== sv/arcs_checker.sv =====
// port checks of the generator and their binding
`default_nettype none
`include "assert_macros.svh"

module arcs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [arcs_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input logic                              o_m_axis_tlast,
    input logic [arcs_pkg::OUT_USER_W-1:0]   o_m_axis_tuser
);
    import arcs_pkg::*;

    // a stalled word holds
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
    // no new item while a run is still going
    `ASSERT_CLK(a_busy, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
    // out of range words carry zero cosine and sine
    `ASSERT_CLK(a_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata[36:5] == 32'd0)
    // the last word is the final row frequency
    `ASSERT_CLK(a_last, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser[0] && o_m_axis_tdata[4:0] == 5'(NFREQ - 1))
    // reset empties the output
    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind axial_rope_cos_sin_generator arcs_checker u_arcs_checker (.*);

`default_nettype wire
